// File: rtl/mpmb_pkg.sv
`default_nettype none
package mpmb_pkg;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctl_t;

  localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
  localparam logic [24:0] BETA_ONE = 25'd16777216;
  localparam int          MAX_ANG  = 42;
  localparam int          ANG_IW   = 6;

  typedef logic [63:0] ang_arr_t [MAX_ANG];

  // Restoring long division on 64-bit words, used only while building the angle table.
  function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) by its power series in Q60, truncated to fb fraction bits.
  function automatic ang_arr_t build_angles(input int fb);
    ang_arr_t    tab;
    logic [63:0] sum;
    logic [63:0] term;
    int          e;
    for (int i = 0; i < MAX_ANG; i++) begin
      tab[i] = '0;
      if (i == 0) begin
        tab[i] = (PI_Q60 >> 2) >> (60 - fb);
      end else if (i < fb + 2) begin
        sum = '0;
        for (int k = 0; k < 31; k++) begin
          e = i * (2 * k + 1);
          if (e <= 60) begin
            term = long_div(64'd1 << (60 - e), 64'(2 * k + 1));
            if (k % 2 == 1) sum = sum - term;
            else sum = sum + term;
          end
        end
        tab[i] = sum >> (60 - fb);
      end
    end
    return tab;
  endfunction

endpackage
`default_nettype wire

// File: rtl/mpmb_alu.sv
`default_nettype none
module mpmb_alu #(
  parameter int W  = 32,
  parameter int FB = 24
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mpmb_pkg::alu_ctl_t ctl,
  input  wire logic signed [W-1:0] a,
  input  wire logic signed [W-1:0] b,
  output logic                    done,
  output logic signed [W-1:0]     y
);
  import mpmb_pkg::*;

  localparam int NW = W + FB;
  localparam int SW = (NW + 1) / 2;
  localparam int RW = SW + 3;
  localparam int CW = $clog2(NW + 1);

  typedef enum logic [1:0] {A_IDLE, A_RUN, A_FIN} ast_t;

  ast_t          st;
  alu_op_t       op;
  logic          neg;
  logic [CW-1:0] cnt;
  logic [W-1:0]  mb, hi, lo, dd;
  logic [W:0]    r;
  logic [NW-1:0] dn;
  logic [2*SW-1:0] sn;
  logic [RW-1:0] rem;
  logic [SW-1:0] root;

  logic [W-1:0]  ua, ub, mag;
  logic [W:0]    mt, drt;
  logic          dge, sge;
  logic [RW-1:0] srt, trial;
  logic [2*W-1:0] prod;

  assign ua = a[W-1] ? W'(-a) : W'(a);
  assign ub = b[W-1] ? W'(-b) : W'(b);

  assign mt    = lo[0] ? ({1'b0, hi} + {1'b0, mb}) : {1'b0, hi};
  assign drt   = {r[W-1:0], dn[NW-1]};
  assign dge   = drt >= {1'b0, dd};
  assign srt   = {rem[RW-3:0], sn[2*SW-1:2*SW-2]};
  assign trial = RW'({root, 2'b01});
  assign sge   = srt >= trial;
  assign prod  = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= A_IDLE;
    end else begin
      case (st)
        A_IDLE: begin
          if (ctl.start) begin
            op   <= ctl.op;
            neg  <= (ctl.op != OP_SQRT) && (a[W-1] ^ b[W-1]);
            mb   <= ua;
            lo   <= ub;
            hi   <= '0;
            dd   <= ub;
            r    <= '0;
            dn   <= {ua, {FB{1'b0}}};
            sn   <= (2*SW)'({ua, {FB{1'b0}}});
            rem  <= '0;
            root <= '0;
            st   <= A_RUN;
            case (ctl.op)
              OP_MUL:  cnt <= CW'(W);
              OP_DIV:  cnt <= CW'(NW);
              default: cnt <= CW'(SW);
            endcase
            if (ctl.op == OP_DIV && (ub == '0 || {1'b0, ua} >= {ub, 1'b0})) begin
              dn <= NW'(2) << FB;
              st <= A_FIN;
            end
            if (ctl.op == OP_SQRT && (a[W-1] || a == '0)) begin
              st <= A_FIN;
            end
          end
        end
        A_RUN: begin
          case (op)
            OP_MUL: begin
              hi <= mt[W:1];
              lo <= {mt[0], lo[W-1:1]};
            end
            OP_DIV: begin
              r  <= dge ? (drt - {1'b0, dd}) : drt;
              dn <= {dn[NW-2:0], dge};
            end
            default: begin
              rem  <= sge ? (srt - trial) : srt;
              root <= {root[SW-2:0], sge};
              sn   <= {sn[2*SW-3:0], 2'b00};
            end
          endcase
          cnt <= cnt - 1'b1;
          if (cnt == CW'(1)) st <= A_FIN;
        end
        A_FIN: st <= A_IDLE;
        default: st <= A_IDLE;
      endcase
    end
  end

  always_comb begin
    case (op)
      OP_MUL:  mag = prod[FB +: W];
      OP_DIV:  mag = dn[W-1:0];
      default: mag = W'(root);
    endcase
    y = neg ? -$signed(mag) : $signed(mag);
  end

  assign done = (st == A_FIN);

endmodule
`default_nettype wire

// File: rtl/mp_median_bisection_core.sv
`default_nettype none
// Channel   Ports                       Transfer
// input     start, busy, beta           rising edge with start high and busy low
// result    done, median, valid_res     the one cycle in which done is high
//
// One item runs setup (a square root and five products) and then up to
// MAX_HALVINGS bisection steps through the shared serial multiply, divide and
// square-root unit plus a CORDIC pass per arcsine. The datapath is
// W = FRAC_BITS+8 bits wide; a step costs roughly 7 products, 3 divides, 3 roots and
// two CORDIC passes. An invalid beta gives its result in the cycle after transfer.
// Reset is synchronous and clears the sequencer. The receiver cannot stall.
module mp_median_bisection_core #(
  parameter int FRAC_BITS    = 24,
  parameter int MAX_HALVINGS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [24:0] beta,
  output logic             done,
  output logic [26:0]      median,
  output logic             valid_res
);
  import mpmb_pkg::*;

  localparam int W    = FRAC_BITS + 8;
  localparam int NANG = FRAC_BITS + 2;
  localparam int AW   = $clog2(NANG);
  localparam int HW   = $clog2(MAX_HALVINGS + 1);
  localparam int SHR  = (FRAC_BITS >= 24) ? FRAC_BITS - 24 : 0;
  localparam int SHL  = (FRAC_BITS < 24) ? 24 - FRAC_BITS : 0;
  localparam int BW   = 25 + SHR;
  localparam int MW   = W + SHL;
  localparam logic signed [W-1:0] ONE    = W'(64'd1 << FRAC_BITS);
  localparam logic signed [W-1:0] HALF   = ONE >>> 1;
  localparam logic signed [W-1:0] PI     = W'(PI_Q60 >> (60 - FRAC_BITS));
  localparam logic signed [W-1:0] TWO_PI = PI <<< 1;
  localparam ang_arr_t ANG = build_angles(FRAC_BITS);

  typedef enum logic [4:0] {
    S_IDLE, S_ROOT, S_LO, S_HI, S_EP, S_PIB, S_DENF, S_MID, S_T1, S_ACC,
    S_Q1, S_SQ, S_XR, S_COR, S_ZM, S_M1, S_M2, S_Q2, S_F
  } state_t;

  state_t                state;
  logic                  pend, pass2;
  logic [HW-1:0]         step;
  logic [AW-1:0]         cnt;
  logic signed [W-1:0]   bt, root, lower, upper, lo, hi, ep, pib, denf;
  logic signed [W-1:0]   xm, acc, s, m1, tmp, cx, cy, cz;

  alu_ctl_t              ctl;
  logic                  alu_done, alu_state;
  logic signed [W-1:0]   opa, opb, y;
  logic signed [W-1:0]   se, wd, mid, dx, dy, ang, ay;
  logic [BW-1:0]         bw;
  logic [MW-1:0]         medw;

  function automatic logic signed [W-1:0] clamp1(input logic signed [W-1:0] v);
    return (v < -ONE) ? -ONE : ((v > ONE) ? ONE : v);
  endfunction

  mpmb_alu #(.W(W), .FB(FRAC_BITS)) u_alu (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .a    (opa),
    .b    (opb),
    .done (alu_done),
    .y    (y)
  );

  assign busy = (state != S_IDLE);
  assign se   = (ONE + bt) <<< 1;
  assign wd   = root <<< 2;
  assign mid  = (lo + hi) >>> 1;
  assign bw   = (BW'(beta) << SHR) >> SHL;
  assign medw = (MW'(mid) >> SHR) << SHL;
  assign ay   = cy[W-1] ? -cy : cy;
  assign dx   = cy[W-1] ? -(ay >> cnt) : (ay >> cnt);
  assign dy   = cx >> cnt;
  assign ang  = W'(ANG[ANG_IW'(cnt)]);

  always_comb begin
    alu_state = 1'b1;
    ctl.op    = OP_MUL;
    opa       = '0;
    opb       = '0;
    case (state)
      S_ROOT: begin ctl.op = OP_SQRT; opa = bt; end
      S_LO:   begin opa = ONE - root; opb = ONE - root; end
      S_HI:   begin opa = ONE + root; opb = ONE + root; end
      S_EP:   begin opa = ONE - bt; opb = ONE - bt; end
      S_PIB:  begin opa = PI; opb = bt; end
      S_DENF: begin opa = TWO_PI; opb = bt; end
      S_T1:   begin opa = upper - xm; opb = xm - lower; end
      S_ACC:  begin ctl.op = OP_SQRT; opa = tmp; end
      S_Q1:   begin ctl.op = OP_DIV; opa = se - (xm <<< 1); opb = wd; end
      S_SQ:   begin opa = s; opb = s; end
      S_XR:   begin ctl.op = OP_SQRT; opa = ONE - tmp; end
      S_ZM:   begin opa = pass2 ? (ONE - bt) : (ONE + bt); opb = cz; end
      S_M1:   begin opa = se; opb = xm; end
      S_M2:   begin opa = xm; opb = wd; end
      S_Q2:   begin ctl.op = OP_DIV; opa = m1 - (ep <<< 1); opb = tmp; end
      S_F:    begin ctl.op = OP_DIV; opa = acc + pib; opb = denf; end
      default: alu_state = 1'b0;
    endcase
    ctl.start = alu_state && !pend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) pend <= 1'b1;
      if (alu_done) pend <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            if (beta == '0 || beta > BETA_ONE) begin
              done      <= 1'b1;
              median    <= '0;
              valid_res <= 1'b0;
            end else begin
              bt    <= (bw == '0) ? W'(1) : W'(bw);
              step  <= '0;
              state <= S_ROOT;
            end
          end
        end
        S_ROOT: if (alu_done) begin root <= y; state <= S_LO; end
        S_LO:   if (alu_done) begin lo <= y; lower <= y; state <= S_HI; end
        S_HI:   if (alu_done) begin hi <= y; upper <= y; state <= S_EP; end
        S_EP:   if (alu_done) begin ep <= y; state <= S_PIB; end
        S_PIB:  if (alu_done) begin pib <= y; state <= S_DENF; end
        S_DENF: if (alu_done) begin denf <= y; state <= S_MID; end
        S_MID: begin
          if (step == HW'(MAX_HALVINGS) || mid <= lo || mid >= hi) begin
            done      <= 1'b1;
            median    <= 27'(medw);
            valid_res <= 1'b1;
            state     <= S_IDLE;
          end else if (mid <= lower) begin
            lo   <= mid;
            step <= step + 1'b1;
          end else if (mid >= upper) begin
            hi   <= mid;
            step <= step + 1'b1;
          end else begin
            xm    <= mid;
            pass2 <= 1'b0;
            state <= S_T1;
          end
        end
        S_T1:  if (alu_done) begin tmp <= y; state <= S_ACC; end
        S_ACC: if (alu_done) begin acc <= y; state <= S_Q1; end
        S_Q1:  if (alu_done) begin s <= clamp1(y); state <= S_SQ; end
        S_SQ:  if (alu_done) begin tmp <= y; state <= S_XR; end
        S_XR: begin
          if (alu_done) begin
            cx    <= y;
            cy    <= s;
            cz    <= '0;
            cnt   <= '0;
            state <= S_COR;
          end
        end
        S_COR: begin
          if (cy > 0) begin
            cx <= cx + dx;
            cy <= cy - dy;
            cz <= cz + ang;
          end else if (cy < 0) begin
            cx <= cx - dx;
            cy <= cy + dy;
            cz <= cz - ang;
          end
          cnt <= cnt + 1'b1;
          if (cnt == AW'(NANG - 1)) state <= S_ZM;
        end
        S_ZM: begin
          if (alu_done) begin
            acc   <= acc - y;
            state <= pass2 ? S_F : S_M1;
          end
        end
        S_M1: if (alu_done) begin m1 <= y; state <= S_M2; end
        S_M2: if (alu_done) begin tmp <= y; state <= S_Q2; end
        S_Q2: begin
          if (alu_done) begin
            s     <= clamp1(y);
            pass2 <= 1'b1;
            state <= S_SQ;
          end
        end
        S_F: begin
          if (alu_done) begin
            // A negative CDF is not clamped here; it still counts as below one half.
            if (y < HALF) lo <= xm;
            else hi <= xm;
            step  <= step + 1'b1;
            state <= S_MID;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: verif/mp_median_checker.sv
module mp_median_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [24:0] beta,
  input  wire logic        done,
  input  wire logic [26:0] median,
  input  wire logic        valid_res,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import mpmb_pkg::*;

  localparam int FB      = 24;
  localparam int HALVING = 32;
  localparam int NA      = FB + 2;
  localparam longint ONE = longint'(1) << FB;

  typedef struct {
    logic [26:0] median;
    logic        valid_res;
  } median_res_t;

  median_res_t expected_medians[$];
  longint      atan_tab[NA];

  function automatic longint unsigned mag_of(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint signed_mag(longint unsigned m, bit neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint shr_zero(longint v, int s);
    return v < 0 ? -longint'(mag_of(v) >> s) : longint'(longint'(unsigned'(v)) >>> 0) >> s;
  endfunction

  function automatic longint q_mul(longint p, longint q);
    logic [127:0] pr;
    pr = {64'd0, 64'(mag_of(p))} * {64'd0, 64'(mag_of(q))};
    return signed_mag(pr[FB+63:FB], (p < 0) != (q < 0));
  endfunction

  function automatic longint q_div(longint n, longint d);
    longint unsigned un, ud, qt, rm;
    bit neg;
    un  = mag_of(n);
    ud  = mag_of(d);
    neg = (n < 0) != (d < 0);
    if (ud == 0 || un >= 2 * ud) return signed_mag(64'd2 << FB, neg);
    qt = un / ud;
    rm = un % ud;
    for (int k = 0; k < FB; k++) begin
      rm = rm << 1;
      qt = qt << 1;
      if (rm >= ud) begin
        rm = rm - ud;
        qt = qt | 1;
      end
    end
    return signed_mag(qt, neg);
  endfunction

  function automatic longint unsigned bit_at(longint unsigned v, int pos);
    if (pos < FB || pos - FB > 62) return 0;
    return (v >> (pos - FB)) & 1;
  endfunction

  function automatic longint q_sqrt(longint v);
    longint unsigned uv, rem, root, trial;
    if (v <= 0) return 0;
    uv   = v;
    rem  = 0;
    root = 0;
    for (int p = (62 + FB) & ~1; p >= 0; p -= 2) begin
      rem   = (rem << 2) | (bit_at(uv, p + 1) << 1) | bit_at(uv, p);
      root  = root << 1;
      trial = (root << 1) | 1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = root | 1;
      end
    end
    return root;
  endfunction

  function automatic longint sat_pm_one(longint v);
    return v < -ONE ? -ONE : (v > ONE ? ONE : v);
  endfunction

  // Vectoring CORDIC on (sqrt(1 - s^2), s) drives y to zero; z collects the angle.
  function automatic longint q_asin(longint s);
    longint x, y, z, dx, dy;
    x = q_sqrt(ONE - q_mul(s, s));
    y = s;
    z = 0;
    for (int i = 0; i < NA; i++) begin
      dx = shr_zero(y, i);
      dy = shr_zero(x, i);
      if (y > 0) begin
        x += dx;
        y -= dy;
        z += atan_tab[i];
      end else if (y < 0) begin
        x -= dx;
        y += dy;
        z -= atan_tab[i];
      end
    end
    return z;
  endfunction

  function automatic longint mp_dist(longint x, longint bt, longint root, longint lower,
                                     longint upper);
    longint pi_q, sum_edges, width, edge_prod, acc, f;
    pi_q = longint'(PI_Q60 >> (60 - FB));
    if (x <= lower) return 0;
    if (x >= upper) return ONE;
    sum_edges = 2 * (ONE + bt);
    width     = 4 * root;
    edge_prod = q_mul(ONE - bt, ONE - bt);
    acc = q_sqrt(q_mul(upper - x, x - lower));
    acc -= q_mul(ONE + bt, q_asin(sat_pm_one(q_div(sum_edges - 2 * x, width))));
    acc -= q_mul(ONE - bt, q_asin(sat_pm_one(q_div(q_mul(sum_edges, x) - 2 * edge_prod,
                                                   q_mul(x, width)))));
    f = q_div(acc + q_mul(pi_q, bt), q_mul(2 * pi_q, bt));
    return f < 0 ? 0 : (f > ONE ? ONE : f);
  endfunction

  function automatic median_res_t predict_median(logic [24:0] raw);
    median_res_t r;
    longint bt, root, lo, hi, mid, lower, upper;
    r.median    = '0;
    r.valid_res = 1'b0;
    if (raw == 0 || raw > BETA_ONE) return r;
    bt = FB >= 24 ? longint'(raw) << (FB - 24) : longint'(raw) >> (24 - FB);
    if (bt == 0) bt = 1;
    root  = q_sqrt(bt);
    lo    = q_mul(ONE - root, ONE - root);
    hi    = q_mul(ONE + root, ONE + root);
    lower = lo;
    upper = hi;
    for (int i = 0; i < HALVING; i++) begin
      mid = (lo + hi) >>> 1;
      if (mid <= lo || mid >= hi) break;
      if (mp_dist(mid, bt, root, lower, upper) < (ONE >>> 1)) lo = mid;
      else hi = mid;
    end
    mid = (lo + hi) >>> 1;
    r.median    = FB >= 24 ? 27'(mid >> (FB - 24)) : 27'(mid << (24 - FB));
    r.valid_res = 1'b1;
    return r;
  endfunction

  initial begin
    longint sum, term;
    int e;
    atan_tab[0] = longint'((PI_Q60 >> 2) >> (60 - FB));
    for (int i = 1; i < NA; i++) begin
      sum = 0;
      for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
        e    = i * (2 * k + 1);
        term = longint'((64'd1 << (60 - e)) / 64'(2 * k + 1));
        sum  = (k % 2 == 1) ? sum - term : sum + term;
      end
      atan_tab[i] = longint'(64'(sum) >> (60 - FB));
    end
  end

  initial fail_count = 0;
  assign pending = expected_medians.size();

  always @(posedge clk) begin
    median_res_t want;
    if (!rst) begin
      if (start && !busy) expected_medians.push_back(predict_median(beta));
      if (done) begin
        if (expected_medians.size() == 0) begin
          $error("result with no transfer outstanding: median=%0d valid_res=%0d",
                 median, valid_res);
          fail_count++;
        end else begin
          want = expected_medians.pop_front();
          if (median !== want.median) begin
            $error("median: expected %0d, got %0d", want.median, median);
            fail_count++;
          end
          if (valid_res !== want.valid_res) begin
            $error("valid_res: expected %0d, got %0d", want.valid_res, valid_res);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// File: verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mpmb_pkg::*;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [24:0] beta;
  logic        done;
  logic [26:0] median;
  logic        valid_res;
  int          fail_count;
  int          pending;
  int          n_valid;
  int          n_invalid;
  int          idle_pct;

  mp_median_bisection_core uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .beta      (beta),
    .done      (done),
    .median    (median),
    .valid_res (valid_res)
  );

  mp_median_checker chk (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .beta       (beta),
    .done       (done),
    .median     (median),
    .valid_res  (valid_res),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One transfer: optional idle cycles, then hold start until busy is low.
  task automatic send_beta(logic [24:0] b);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    beta  <= b;
    forever begin
      @(negedge clk);
      if (!busy) break;
      @(posedge clk);
    end
    @(posedge clk);
    if (b == 0 || b > BETA_ONE) n_invalid++;
    else n_valid++;
  endtask

  function automatic logic [24:0] random_beta();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return 25'($urandom_range(33554431, 16777217));
    if (pick < 15) return 25'($urandom_range(255, 1));
    if (pick < 20) return 25'($urandom_range(16777216, 16776000));
    return 25'($urandom_range(16777216, 1));
  endfunction

  initial begin
    logic [24:0] directed[$];
    start     = 1'b0;
    beta      = '0;
    rst       = 1'b1;
    idle_pct  = 0;
    n_valid   = 0;
    n_invalid = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Edges of the range, tiny ratios, invalid codes and alternating bit patterns.
    directed = '{25'd0, 25'd1, 25'd2, 25'd3, 25'd16777216, 25'd16777215, 25'd16777217,
                 25'h1FFFFFF, 25'd8388608, 25'd4194304, 25'h0AAAAAA, 25'h0555555,
                 25'h1555555, 25'h0FFFFFF, 25'd65536, 25'd256, 25'h1000001};
    foreach (directed[i]) send_beta(directed[i]);

    // Let the block drain completely before the random part.
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    for (int i = 0; i < 124; i++) begin
      case (i / 31)
        0:       idle_pct = 0;
        1:       idle_pct = 56;
        2:       idle_pct = 0;
        default: idle_pct = 20;
      endcase
      send_beta(random_beta());
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Covered %0d in-range and %0d out-of-range aspect ratios", n_valid, n_invalid);
    $display("under back-to-back and randomly gapped start pulses.");
    if (fail_count == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    #500ms;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
